// ----- design/pe32va_pkg.sv -----
// shared types and constants for the pe32 virtual address resolver
`timescale 1ns / 1ps
`default_nettype none
package pe32va_pkg;

  localparam int DEFAULT_IMAGE_BYTES = 65536;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [15:0] MZ_SIG = 16'h5a4d;
  localparam logic [31:0] PE_SIG = 32'h0000_4550;
  localparam logic [15:0] PE32_MAGIC = 16'h010b;

  localparam int MIN_LEN = 'h40;
  localparam int NT_PTR_AT = 'h3c;
  localparam int NT_SIZE = 'h18;
  localparam int COUNT_AT = 'h06;
  localparam int OPT_SIZE_AT = 'h14;
  localparam int BASE_AT = 'h1c;
  localparam int MIN_OPT = 'h20;
  localparam int SEC_SIZE = 'h28;
  localparam int VSIZE_AT = 'h08;
  localparam int VSTART_AT = 'h0c;
  localparam int RSIZE_AT = 'h10;
  localparam int RSTART_AT = 'h14;

  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_SPAN = 2'd1;
  localparam logic [1:0] CMD_STR = 2'd2;
  localparam logic [1:0] CMD_CLEAR = 2'd3;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_SPAN,
    OP_STR,
    OP_CLEAR
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [7:0]  image_byte;
    logic [31:0] virtual_address;
    logic [31:0] byte_count;
  } item_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_RDI,
    S_RDW,
    S_MZ,
    S_NT,
    S_SIG,
    S_CNT,
    S_OPT,
    S_MAGIC,
    S_BASE,
    S_SEC,
    S_VSZ,
    S_VST,
    S_RSZ,
    S_RST,
    S_CHK,
    S_HIT,
    S_SCAN,
    S_SCANW,
    S_PASS,
    S_FAIL
  } state_t;

endpackage
`default_nettype wire

// ----- design/pe32va_front.sv -----
// front end: command decode and word queue toward the back end
`timescale 1ns / 1ps
`default_nettype none
module pe32va_front (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  push,
  output logic                 full,
  input  wire  [1:0]           command,
  input  wire  [7:0]           image_byte,
  input  wire  [31:0]          virtual_address,
  input  wire  [31:0]          byte_count,
  output logic                 q_valid,
  output pe32va_pkg::item_t    q_item,
  input  wire                  q_pop
);
  import pe32va_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  item_t         entry [QUEUE_DEPTH];
  logic [PW-1:0] head;
  logic [PW-1:0] tail;
  logic [CW-1:0] count;
  op_t           op;
  logic          do_push;
  logic          do_pop;

  always_comb begin
    unique case (command)
      CMD_LOAD:  op = OP_LOAD;
      CMD_SPAN:  op = OP_SPAN;
      CMD_STR:   op = OP_STR;
      CMD_CLEAR: op = OP_CLEAR;
      default:   op = OP_LOAD;
    endcase
  end

  assign full    = (count == CW'(QUEUE_DEPTH));
  assign q_valid = (count != '0);
  assign q_item  = entry[head];
  assign do_push = push && !full;
  assign do_pop  = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[tail] <= '{op: op, image_byte: image_byte,
                       virtual_address: virtual_address, byte_count: byte_count};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        tail <= (tail == PW'(QUEUE_DEPTH - 1)) ? '0 : PW'(tail + 1'b1);
      end
      if (do_pop) begin
        head <= (head == PW'(QUEUE_DEPTH - 1)) ? '0 : PW'(head + 1'b1);
      end
      if (do_push && !do_pop) begin
        count <= CW'(count + 1'b1);
      end else if (do_pop && !do_push) begin
        count <= CW'(count - 1'b1);
      end
    end
  end

endmodule
`default_nettype wire

// ----- design/pe32va_back.sv -----
// back end: byte store, header and section walk sequencer, result register
`timescale 1ns / 1ps
`default_nettype none
module pe32va_back #(
  parameter int IMAGE_BYTES = pe32va_pkg::DEFAULT_IMAGE_BYTES
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  q_valid,
  input  pe32va_pkg::item_t    q_item,
  output logic                 q_pop,
  output logic                 out_valid,
  output logic                 out_found,
  output logic [15:0]          out_off,
  input  wire                  out_pop
);
  import pe32va_pkg::*;

  localparam int AW = $clog2(IMAGE_BYTES);
  localparam int LW = $clog2(IMAGE_BYTES + 1);

  logic [7:0]    mem [IMAGE_BYTES];
  logic [7:0]    rdata;
  logic [AW-1:0] raddr;

  state_t        state;
  state_t        state_next;
  state_t        ret;
  logic [LW-1:0] len;
  logic [AW-1:0] rd_addr;
  logic [1:0]    rd_idx;
  logic [1:0]    rd_last;
  logic [31:0]   acc;
  op_t           cmd;
  logic [31:0]   va;
  logic [31:0]   need;
  logic [AW-1:0] nt;
  logic [15:0]   count;
  logic [15:0]   opt_size;
  logic [LW-1:0] opt;
  logic [31:0]   rva;
  logic [LW-1:0] entry;
  logic [15:0]   sec_i;
  logic [31:0]   vsize;
  logic [31:0]   diff;
  logic [31:0]   extent;
  logic          hit_lo;
  logic          hit;
  logic [32:0]   off;
  logic [LW-1:0] scan_k;

  logic [32:0]   len_w;
  logic [32:0]   opt_w;
  logic          opt_bad;
  logic          res_go;

  assign len_w   = 33'(len);
  assign opt_w   = 33'(nt) + 33'(NT_SIZE);
  assign opt_bad = (opt_w + 33'(acc[31:16]) > len_w) || (opt_w + 33'(MIN_OPT) > len_w);
  assign res_go  = !out_valid || out_pop;
  assign q_pop   = (state == S_IDLE) && q_valid;
  assign raddr   = (state == S_SCAN) ? AW'(scan_k) : AW'(rd_addr + AW'(rd_idx));

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (q_valid && (q_item.op == OP_SPAN || q_item.op == OP_STR)) begin
          state_next = (len < LW'(MIN_LEN)) ? S_FAIL : S_RDI;
        end
      end
      S_RDI:   state_next = S_RDW;
      S_RDW:   state_next = (rd_idx == rd_last) ? ret : S_RDI;
      S_MZ:    state_next = (acc[31:16] == MZ_SIG) ? S_RDI : S_FAIL;
      S_NT:    state_next = (33'(acc) + 33'(NT_SIZE) > len_w) ? S_FAIL : S_RDI;
      S_SIG:   state_next = (acc == PE_SIG) ? S_RDI : S_FAIL;
      S_CNT:   state_next = S_RDI;
      S_OPT:   state_next = opt_bad ? S_FAIL : S_RDI;
      S_MAGIC: state_next = (acc[31:16] == PE32_MAGIC) ? S_RDI : S_FAIL;
      S_BASE:  state_next = (va < acc) ? S_FAIL : S_SEC;
      S_SEC: begin
        if (sec_i == count || 33'(entry) + 33'(SEC_SIZE) > len_w) begin
          state_next = S_FAIL;
        end else begin
          state_next = S_RDI;
        end
      end
      S_VSZ:   state_next = S_RDI;
      S_VST:   state_next = S_RDI;
      S_RSZ:   state_next = S_RDI;
      S_RST:   state_next = S_CHK;
      S_CHK:   state_next = hit ? S_HIT : S_SEC;
      S_HIT: begin
        if (off >= len_w) begin
          state_next = S_FAIL;
        end else if (cmd == OP_SPAN) begin
          state_next = (33'(need) > len_w - off) ? S_FAIL : S_PASS;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_SCAN:  state_next = (scan_k == len) ? S_FAIL : S_SCANW;
      S_SCANW: state_next = (rdata == 8'd0) ? S_PASS : S_SCAN;
      S_PASS:  state_next = res_go ? S_IDLE : S_PASS;
      S_FAIL:  state_next = res_go ? S_IDLE : S_FAIL;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && q_valid && q_item.op == OP_LOAD && len < LW'(IMAGE_BYTES)) begin
      mem[AW'(len)] <= q_item.image_byte;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      len       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && out_pop && state != S_PASS && state != S_FAIL) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            cmd     <= q_item.op;
            va      <= q_item.virtual_address;
            need    <= q_item.byte_count;
            rd_addr <= '0;
            rd_idx  <= '0;
            rd_last <= 2'd1;
            ret     <= S_MZ;
            if (q_item.op == OP_LOAD && len < LW'(IMAGE_BYTES)) begin
              len <= LW'(len + 1'b1);
            end else if (q_item.op == OP_CLEAR) begin
              len <= '0;
            end
          end
        end
        S_RDW: begin
          acc    <= {rdata, acc[31:8]};
          rd_idx <= rd_idx + 2'd1;
        end
        S_MZ: begin
          rd_addr <= AW'(NT_PTR_AT);
          rd_idx  <= '0;
          rd_last <= 2'd3;
          ret     <= S_NT;
        end
        S_NT: begin
          nt      <= acc[AW-1:0];
          rd_addr <= acc[AW-1:0];
          rd_idx  <= '0;
          rd_last <= 2'd3;
          ret     <= S_SIG;
        end
        S_SIG: begin
          rd_addr <= AW'(nt + AW'(COUNT_AT));
          rd_idx  <= '0;
          rd_last <= 2'd1;
          ret     <= S_CNT;
        end
        S_CNT: begin
          count   <= acc[31:16];
          rd_addr <= AW'(nt + AW'(OPT_SIZE_AT));
          rd_idx  <= '0;
          rd_last <= 2'd1;
          ret     <= S_OPT;
        end
        S_OPT: begin
          opt_size <= acc[31:16];
          opt      <= LW'(opt_w);
          rd_addr  <= AW'(opt_w);
          rd_idx   <= '0;
          rd_last  <= 2'd1;
          ret      <= S_MAGIC;
        end
        S_MAGIC: begin
          rd_addr <= AW'(opt + LW'(BASE_AT));
          rd_idx  <= '0;
          rd_last <= 2'd3;
          ret     <= S_BASE;
        end
        S_BASE: begin
          rva   <= va - acc;
          entry <= LW'(33'(opt) + 33'(opt_size));
          sec_i <= '0;
        end
        S_SEC: begin
          rd_addr <= AW'(entry + LW'(VSIZE_AT));
          rd_idx  <= '0;
          rd_last <= 2'd3;
          ret     <= S_VSZ;
        end
        S_VSZ: begin
          vsize   <= acc;
          rd_addr <= AW'(entry + LW'(VSTART_AT));
          rd_idx  <= '0;
          ret     <= S_VST;
        end
        S_VST: begin
          hit_lo  <= (rva >= acc);
          diff    <= rva - acc;
          rd_addr <= AW'(entry + LW'(RSIZE_AT));
          rd_idx  <= '0;
          ret     <= S_RSZ;
        end
        S_RSZ: begin
          extent  <= (vsize > acc) ? vsize : acc;
          rd_addr <= AW'(entry + LW'(RSTART_AT));
          rd_idx  <= '0;
          ret     <= S_RST;
        end
        S_RST: begin
          hit <= hit_lo && (diff < extent);
          off <= 33'(diff) + 33'(acc);
        end
        S_CHK: begin
          if (!hit) begin
            entry <= LW'(33'(entry) + 33'(SEC_SIZE));
            sec_i <= sec_i + 16'd1;
          end
        end
        S_HIT: begin
          scan_k <= off[LW-1:0];
        end
        S_SCANW: begin
          scan_k <= LW'(scan_k + 1'b1);
        end
        S_PASS: begin
          if (res_go) begin
            out_valid <= 1'b1;
            out_found <= 1'b1;
            out_off   <= off[15:0];
          end
        end
        S_FAIL: begin
          if (res_go) begin
            out_valid <= 1'b1;
            out_found <= 1'b0;
            out_off   <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    len <= LW'(IMAGE_BYTES))
    else $error("image length past store size");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_found |-> out_off == 16'd0)
    else $error("offset nonzero on miss");

  a_clear_len: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE && q_valid && q_item.op == OP_CLEAR |=> len == '0)
    else $error("clear did not zero length");

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> state == S_IDLE)
    else $error("queue popped while busy");
`endif

endmodule
`default_nettype wire

// ----- design/pe32_virtual_address_to_offset_core.sv -----
// top level of the pe32 virtual address to file offset resolver
`timescale 1ns / 1ps
`default_nettype none
// A load or clear word is handled in the back end's idle state alone; a query
// walks the headers and section table through the single-port byte store, each
// byte read going through S_RDI and S_RDW: header checks first, then each
// section entry visited, and for a string query a scan of bytes to the zero.
// A two-word queue lets loads and queries be pushed while the walk runs, and one
// result register holds the answer until it is popped.
module pe32_virtual_address_to_offset_core #(
  parameter int IMAGE_BYTES = pe32va_pkg::DEFAULT_IMAGE_BYTES
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         push,
  output logic        full,
  input  wire  [1:0]  command,
  input  wire  [7:0]  image_byte,
  input  wire  [31:0] virtual_address,
  input  wire  [31:0] byte_count,
  output logic        empty,
  input  wire         pop,
  output logic        found,
  output logic [15:0] file_offset
);
  import pe32va_pkg::*;

  item_t q_item;
  logic  q_valid;
  logic  q_pop;
  logic  out_valid;

  pe32va_front u_front (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .full            (full),
    .command         (command),
    .image_byte      (image_byte),
    .virtual_address (virtual_address),
    .byte_count      (byte_count),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .q_pop           (q_pop)
  );

  pe32va_back #(
    .IMAGE_BYTES (IMAGE_BYTES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_found (found),
    .out_off   (file_offset),
    .out_pop   (pop)
  );

  assign empty = !out_valid;

endmodule
`default_nettype wire

// ----- test/pe32_virtual_address_to_offset_core_test.sv -----
// testbench for the pe32 virtual address resolver: byte-loaded images, span and string queries
`timescale 1ns / 1ps
module pe32_virtual_address_to_offset_core_test;
  import pe32va_pkg::*;

  localparam int STORE_BYTES = 65536;
  localparam int IDLE_LIMIT = 400000;

  typedef struct {
    logic        found;
    logic [15:0] offset;
  } answer_t;

  logic        clk = 0;
  logic        rst = 1;
  logic        push = 0;
  logic [1:0]  command = CMD_LOAD;
  logic [7:0]  image_byte = 0;
  logic [31:0] virtual_address = 0;
  logic [31:0] byte_count = 0;
  logic        pop = 0;
  wire         full;
  wire         empty;
  wire         found;
  wire  [15:0] file_offset;

  pe32_virtual_address_to_offset_core uut (
    .clk(clk), .rst(rst), .push(push), .full(full), .command(command),
    .image_byte(image_byte), .virtual_address(virtual_address), .byte_count(byte_count),
    .empty(empty), .pop(pop), .found(found), .file_offset(file_offset)
  );

  always #1 clk = ~clk;

  item_t       pending_words[$];
  answer_t     expected_answers[$];
  logic [7:0]  model_store [0:STORE_BYTES-1];
  int unsigned model_len = 0;
  int          errors = 0;
  int          words_in = 0;
  int          idle_cycles = 0;
  logic        in_fire = 0;

  // image under construction
  logic [7:0]  img [0:1023];
  int          img_len;
  int          img_nt;
  int          img_nsec;
  logic [31:0] img_base;
  logic [31:0] sec_vst [0:3];
  logic [31:0] sec_ext [0:3];

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic logic [31:0] rd8(input longint unsigned a);
    return (a < STORE_BYTES) ? {24'd0, model_store[a]} : 32'd0;
  endfunction

  function automatic logic [31:0] rd16(input longint unsigned a);
    return rd8(a) | (rd8(a + 1) << 8);
  endfunction

  function automatic logic [31:0] rd32(input longint unsigned a);
    return rd8(a) | (rd8(a + 1) << 8) | (rd8(a + 2) << 16) | (rd8(a + 3) << 24);
  endfunction

  function automatic bit map_va(input logic [31:0] va, output longint unsigned where);
    longint unsigned len, nt, opt, opt_sz, entry, off;
    logic [31:0] nsec, base, rva, vsz, vst, rsz, rstart, ext;
    where = 0;
    len = model_len;
    if (len < MIN_LEN) return 0;
    if (rd16(0) != {16'd0, MZ_SIG}) return 0;
    nt = rd32(NT_PTR_AT);
    if (nt + NT_SIZE > len) return 0;
    if (rd32(nt) != PE_SIG) return 0;
    nsec = rd16(nt + COUNT_AT);
    opt_sz = rd16(nt + OPT_SIZE_AT);
    opt = nt + NT_SIZE;
    if (opt + opt_sz > len || opt + MIN_OPT > len) return 0;
    if (rd16(opt) != {16'd0, PE32_MAGIC}) return 0;
    base = rd32(opt + BASE_AT);
    if (va < base) return 0;
    rva = va - base;
    entry = opt + opt_sz;
    for (longint unsigned i = 0; i < nsec; i++) begin
      if (entry + SEC_SIZE > len) return 0;
      vsz = rd32(entry + VSIZE_AT);
      vst = rd32(entry + VSTART_AT);
      rsz = rd32(entry + RSIZE_AT);
      rstart = rd32(entry + RSTART_AT);
      ext = (vsz > rsz) ? vsz : rsz;
      if (rva >= vst && (rva - vst) < ext) begin
        off = longint'(rva - vst) + longint'(rstart);
        if (off >= len) return 0;
        where = off;
        return 1;
      end
      entry += SEC_SIZE;
    end
    return 0;
  endfunction

  function automatic void apply_word(input item_t w);
    longint unsigned off;
    bit ok;
    answer_t a;
    case (w.op)
      OP_LOAD: begin
        if (model_len < STORE_BYTES) begin
          model_store[model_len] = w.image_byte;
          model_len++;
        end
      end
      OP_CLEAR: model_len = 0;
      default: begin
        ok = map_va(w.virtual_address, off);
        if (ok && w.op == OP_SPAN) begin
          if (longint'(w.byte_count) > longint'(model_len) - off) ok = 0;
        end else if (ok) begin
          ok = 0;
          for (longint unsigned k = off; k < model_len; k++) begin
            if (model_store[k] == 0) begin
              ok = 1;
              break;
            end
          end
        end
        a.found = ok;
        a.offset = ok ? off[15:0] : 16'd0;
        expected_answers.push_back(a);
      end
    endcase
  endfunction

  // checker and predictor
  always @(posedge clk) begin
    answer_t a;
    if (rst) begin
      in_fire <= 0;
    end else begin
      in_fire <= push && !full;
      if (pop && !empty) begin
        if (expected_answers.size() == 0) begin
          report("unexpected word", {15'd0, found, file_offset}, 32'd0);
        end else begin
          a = expected_answers.pop_front();
          if (found !== a.found) report("found", {31'd0, found}, {31'd0, a.found});
          if (file_offset !== a.offset) report("file_offset", {16'd0, file_offset}, {16'd0, a.offset});
        end
      end
      if (push && !full) begin
        apply_word('{op: op_t'(command), image_byte: image_byte,
                     virtual_address: virtual_address, byte_count: byte_count});
        words_in++;
      end
      if ((push && !full) || (pop && !empty)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("DONE: errors detected");
          $finish;
        end
      end
    end
  end

  // sender: bursts with gaps
  int burst_left = 8;
  int gap_left = 0;
  always @(negedge clk) begin
    bit want;
    if (!rst) begin
      if (in_fire) void'(pending_words.pop_front());
      want = 0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_words.size() > 0) begin
        want = 1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
      push <= want;
      if (pending_words.size() > 0) begin
        command <= pending_words[0].op;
        image_byte <= pending_words[0].image_byte;
        virtual_address <= pending_words[0].virtual_address;
        byte_count <= pending_words[0].byte_count;
      end
    end
  end

  // receiver: stall pattern plus one long hold-off
  int pop_mode = 0;
  int mode_left = 100;
  int hold_left = 0;
  bit held_once = 0;
  always @(negedge clk) begin
    bit take;
    if (!rst) begin
      if (!held_once && words_in >= 700) begin
        held_once = 1;
        hold_left = 3000;
      end
      if (--mode_left <= 0) begin
        pop_mode = $urandom_range(0, 2);
        mode_left = $urandom_range(20, 300);
      end
      case (pop_mode)
        0: take = 1;
        1: take = $urandom_range(0, 1);
        default: take = ($urandom_range(0, 4) == 0);
      endcase
      if (hold_left > 0) begin
        hold_left--;
        take = 0;
      end
      pop <= take;
    end
  end

  task automatic add(input op_t op, input logic [7:0] b, input logic [31:0] va,
                     input logic [31:0] cnt);
    item_t w;
    w.op = op;
    w.image_byte = b;
    w.virtual_address = va;
    w.byte_count = cnt;
    pending_words.push_back(w);
  endtask

  task automatic put(input int a, input int n, input logic [31:0] v);
    for (int i = 0; i < n; i++) img[a + i] = v[8*i +: 8];
  endtask

  task automatic make_image(input bit corrupt);
    int opt_sz, tab, data;
    logic [31:0] vsz, rsz, rstart;
    img_nt = MIN_LEN + 4 * $urandom_range(0, 8);
    opt_sz = $urandom_range(0, 1) ? MIN_OPT : MIN_OPT + 4 * $urandom_range(0, 16);
    img_nsec = $urandom_range(0, 3);
    tab = img_nt + NT_SIZE + opt_sz;
    data = tab + SEC_SIZE * img_nsec;
    img_len = data + $urandom_range(32, 120);
    for (int i = 0; i < img_len; i++)
      img[i] = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom);
    img_base = $urandom_range(0, 1) ? 32'h0040_0000 : $urandom;
    put(0, 2, MZ_SIG);
    put(NT_PTR_AT, 4, img_nt);
    put(img_nt, 4, PE_SIG);
    put(img_nt + COUNT_AT, 2, img_nsec);
    put(img_nt + OPT_SIZE_AT, 2, opt_sz);
    put(img_nt + NT_SIZE, 2, PE32_MAGIC);
    put(img_nt + NT_SIZE + BASE_AT, 4, img_base);
    for (int i = 0; i < img_nsec; i++) begin
      sec_vst[i] = ($urandom_range(0, 7) == 0) ? $urandom : 32'h1000 * (i + 1);
      vsz = $urandom_range(0, 64);
      rsz = $urandom_range(0, 64);
      rstart = ($urandom_range(0, 7) == 0) ? $urandom : data + $urandom_range(0, img_len - data);
      sec_ext[i] = (vsz > rsz) ? vsz : rsz;
      put(tab + SEC_SIZE * i + VSIZE_AT, 4, vsz);
      put(tab + SEC_SIZE * i + VSTART_AT, 4, sec_vst[i]);
      put(tab + SEC_SIZE * i + RSIZE_AT, 4, rsz);
      put(tab + SEC_SIZE * i + RSTART_AT, 4, rstart);
    end
    if (corrupt) begin
      case ($urandom_range(0, 5))
        0: img[$urandom_range(0, img_nt + NT_SIZE + MIN_OPT)] ^= 8'(1 << $urandom_range(0, 7));
        1: img_len = $urandom_range(MIN_LEN - 16, img_len);
        default: ;
      endcase
    end
  endtask

  task automatic load_image;
    add(OP_CLEAR, $urandom, $urandom, $urandom);
    for (int i = 0; i < img_len; i++) add(OP_LOAD, img[i], $urandom, $urandom);
  endtask

  function automatic logic [31:0] pick_va;
    int s;
    if (img_nsec == 0 || $urandom_range(0, 4) == 0) return $urandom;
    s = $urandom_range(0, img_nsec - 1);
    return img_base + sec_vst[s] + $urandom_range(0, sec_ext[s] + 3);
  endfunction

  function automatic logic [31:0] pick_count;
    case ($urandom_range(0, 3))
      0: return 0;
      1: return $urandom;
      default: return $urandom_range(0, 140);
    endcase
  endfunction

  initial begin
    // empty image
    add(OP_SPAN, 0, 32'h0, 32'h0);
    add(OP_STR, 8'hff, 32'hffff_ffff, 32'hffff_ffff);
    // short image
    make_image(0);
    img_len = MIN_LEN - 1;
    load_image();
    add(OP_SPAN, 0, img_base + sec_vst[0], 0);
    // well-formed image, extremes of count and address
    do make_image(0); while (img_nsec == 0);
    load_image();
    add(OP_SPAN, 0, img_base + sec_vst[0], 32'h0);
    add(OP_SPAN, 0, img_base + sec_vst[0], 32'hffff_ffff);
    add(OP_SPAN, 0, img_base + sec_vst[0], 1);
    add(OP_STR, 0, img_base + sec_vst[0], 0);
    add(OP_STR, 0, img_base - 1, 0);
    add(OP_SPAN, 0, 32'hffff_ffff, 0);
    add(OP_SPAN, 0, 32'h0, 0);
    // nt headers past the end
    put(NT_PTR_AT, 4, 32'hffff_fff0);
    load_image();
    add(OP_SPAN, 0, img_base + sec_vst[0], 0);
    // section walk past the end
    make_image(0);
    put(img_nt + COUNT_AT, 2, 16'hffff);
    load_image();
    add(OP_SPAN, 0, img_base + 32'h0fff_0000, 0);
    add(OP_STR, 0, img_base + 32'h0fff_0000, 0);
    // random images and queries
    for (int n = 0; n < 300; ) begin
      make_image($urandom_range(0, 4) == 0);
      load_image();
      n += img_len + 1;
      repeat ($urandom_range(8, 20)) begin
        if ($urandom_range(0, 15) == 0) begin
          add(OP_CLEAR, $urandom, $urandom, $urandom);
          n++;
        end
        add($urandom_range(0, 1) ? OP_SPAN : OP_STR, $urandom, pick_va(), pick_count());
        n++;
      end
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 0;
    while (pending_words.size() > 0 || expected_answers.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0 && expected_answers.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/pe32va_pkg.sv
design/pe32va_front.sv
design/pe32va_back.sv
design/pe32_virtual_address_to_offset_core.sv
test/pe32_virtual_address_to_offset_core_test.sv
